>>> rtl/tfc_pkg.sv
// Shared types, constants and the CRC step for the telemetry frame checker.
`default_nettype none

package tfc_pkg;

    // CRC-16 CCITT constants
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    // Register reset values
    localparam logic [31:0] ACCEPT_MAGIC_RST    = 32'h534D4C54;
    localparam logic [31:0] IGNORE_MAGIC_RST    = 32'h314B4341;
    localparam logic [8:0]  EXPECTED_LENGTH_RST = 9'd48;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ACCEPT_MAGIC    = 2'd0,
        CFG_IGNORE_MAGIC    = 2'd1,
        CFG_EXPECTED_LENGTH = 2'd2
    } cfg_index_t;

    // Verdict codes
    typedef enum logic [2:0] {
        ST_VALID     = 3'd0,
        ST_REPLY     = 3'd1,
        ST_OTHER     = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_BAD_CRC   = 3'd4,
        ST_OVERSIZE  = 3'd5
    } frame_status_t;

    // Byte request payload
    typedef struct packed {
        logic [7:0] received_byte;
        logic       last_byte;
    } byte_req_t;

    // Verdict request payload
    typedef struct packed {
        logic [2:0]  frame_status;
        logic [15:0] sequence_number;
        logic [8:0]  frame_length;
    } verdict_t;

    // Per-frame record handed from the front end to the back end
    typedef struct packed {
        logic        oversize;
        logic        len_fits;     // full count below 512
        logic [8:0]  len_low;
        logic [31:0] magic;
        logic [15:0] seq_word;
        logic [15:0] stored_crc;
        logic [15:0] calc_crc;
    } frame_rec_t;

    localparam int QUEUE_DEPTH = 2;

    // One byte through the CRC, MSB first
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/tfc_stream_if.sv
// Valid/ready stream interface carrying one payload type.
`default_nettype none

interface tfc_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/tfc_front.sv
// Front end: takes bytes, tracks frame position, magic, sequence and CRC.
`default_nettype none

module tfc_front
    import tfc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire byte_req_t  in_data,
    output logic            rec_valid,
    input  wire logic       rec_ready,
    output frame_rec_t      rec_data
);

    localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 2);
    localparam int CMP_W = (LEN_W > 10) ? LEN_W : 10;

    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [15:0]      rcrc_reg, rcrc_next;
    logic [31:0]      magic_reg, magic_next;
    logic [15:0]      seq_reg, seq_next;
    logic [15:0]      ccrc_reg, ccrc_next;
    logic             accept;
    logic             in_range;
    logic [CMP_W-1:0] len_wide;

    // Byte is taken whenever the queue has room
    assign in_ready = rec_ready;
    assign accept   = in_valid && in_ready;
    assign in_range = pos_reg < LEN_W'(MAX_FRAME_BYTES);

    // Frame state after this byte
    always_comb
    begin
        pos_next   = pos_reg;
        rcrc_next  = rcrc_reg;
        magic_next = magic_reg;
        seq_next   = seq_reg;
        ccrc_next  = ccrc_reg;
        if (in_range)
        begin
            if (pos_reg < LEN_W'(4))
                magic_next = {in_data.received_byte, magic_reg[31:8]};
            if (pos_reg == LEN_W'(6))
                seq_next = {seq_reg[15:8], in_data.received_byte};
            else if (pos_reg == LEN_W'(7))
                seq_next = {in_data.received_byte, seq_reg[7:0]};
            // CRC runs two bytes behind so the stored CRC stays out of it
            if (pos_reg >= LEN_W'(2))
                rcrc_next = crc_step(rcrc_reg, ccrc_reg[7:0]);
            ccrc_next = {in_data.received_byte, ccrc_reg[15:8]};
            pos_next  = pos_reg + LEN_W'(1);
        end
        else
        begin
            pos_next = LEN_W'(MAX_FRAME_BYTES + 1);
        end
    end

    // Record pushed on the last byte
    assign len_wide = CMP_W'(pos_next);
    assign rec_valid = accept && in_data.last_byte;

    always_comb
    begin
        rec_data.oversize   = pos_next > LEN_W'(MAX_FRAME_BYTES);
        rec_data.len_fits   = len_wide < CMP_W'(512);
        rec_data.len_low    = len_wide[8:0];
        rec_data.magic      = (pos_next >= LEN_W'(4)) ? magic_next : 32'h0;
        rec_data.seq_word   = seq_next;
        rec_data.stored_crc = ccrc_next;
        rec_data.calc_crc   = rcrc_next;
    end

    // Frame state registers, cleared after each last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            rcrc_reg  <= CRC_INIT;
            magic_reg <= '0;
            seq_reg   <= '0;
            ccrc_reg  <= '0;
        end
        else if (accept)
        begin
            if (in_data.last_byte)
            begin
                pos_reg   <= '0;
                rcrc_reg  <= CRC_INIT;
                magic_reg <= '0;
                seq_reg   <= '0;
                ccrc_reg  <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                rcrc_reg  <= rcrc_next;
                magic_reg <= magic_next;
                seq_reg   <= seq_next;
                ccrc_reg  <= ccrc_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/tfc_queue.sv
// Two-entry record queue between front end and back end.
`default_nettype none

module tfc_queue
    import tfc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  wire frame_rec_t push_data,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output frame_rec_t      pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_rec_t       mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tfc_back.sv
// Back end: configuration registers, verdict decision and output register.
`default_nettype none

module tfc_back
    import tfc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data,
    input  wire logic                   rec_valid,
    output logic                        rec_ready,
    input  wire frame_rec_t             rec_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output verdict_t                    out_data
);

    logic [31:0]   accept_magic_reg;
    logic [31:0]   ignore_magic_reg;
    logic [8:0]    expected_length_reg;
    logic          out_valid_reg;
    verdict_t      out_data_reg, out_data_next;
    frame_status_t status;
    logic          load;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_magic_reg    <= ACCEPT_MAGIC_RST;
            ignore_magic_reg    <= IGNORE_MAGIC_RST;
            expected_length_reg <= EXPECTED_LENGTH_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ACCEPT_MAGIC:    accept_magic_reg    <= cfg_data;
                CFG_IGNORE_MAGIC:    ignore_magic_reg    <= cfg_data;
                CFG_EXPECTED_LENGTH: expected_length_reg <= cfg_data[8:0];
                default:             ;
            endcase
        end
    end

    // Verdict in priority order
    always_comb
    begin
        if (rec_data.oversize)
            status = ST_OVERSIZE;
        else if (rec_data.magic == ignore_magic_reg)
            status = ST_REPLY;
        else if (rec_data.magic != accept_magic_reg)
            status = ST_OTHER;
        else if (!(rec_data.len_fits && rec_data.len_low == expected_length_reg))
            status = ST_BAD_LEN;
        else if (rec_data.stored_crc != rec_data.calc_crc)
            status = ST_BAD_CRC;
        else
            status = ST_VALID;
    end

    always_comb
    begin
        out_data_next.frame_status    = status;
        out_data_next.sequence_number = rec_data.seq_word;
        out_data_next.frame_length    = rec_data.len_low;
    end

    // Output register: refills while the current verdict is taken
    assign rec_ready = !out_valid_reg || out_ready;
    assign load      = rec_valid && rec_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rec_ready)
            out_valid_reg <= rec_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

>>> rtl/telemetry_frame_checker_unit.sv
// Top level of the telemetry frame checker.
//
//  channel      dir  payload                                      request
//  frame_in     in   received_byte[7:0], last_byte                one byte
//  verdict_out  out  frame_status[2:0], sequence_number[15:0],    one verdict per frame
//                    frame_length[8:0]
//  cfg_*        in   cfg_index[1:0], cfg_data[31:0]               one register write
//
// One byte per cycle is taken while the record queue has room; the CRC step for a byte is one
// unrolled stage in the front end. Verdicts pass the record queue, then the output register.
// rst_n clears frame state, the queue and the output register; registers return to defaults.
// The two-entry queue lets the front end keep taking bytes while a verdict waits downstream.
`default_nettype none

module telemetry_frame_checker_unit
    import tfc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    tfc_stream_if.sink                  frame_in,
    tfc_stream_if.source                verdict_out,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data
);

    logic       push_valid, push_ready;
    frame_rec_t push_data;
    logic       pop_valid, pop_ready;
    frame_rec_t pop_data;
    byte_req_t  in_data;
    verdict_t   out_data;

    assign in_data.received_byte = frame_in.data.received_byte;
    assign in_data.last_byte     = frame_in.data.last_byte;

    tfc_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frame_in.valid),
        .in_ready  (frame_in.ready),
        .in_data   (in_data),
        .rec_valid (push_valid),
        .rec_ready (push_ready),
        .rec_data  (push_data)
    );

    tfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rec_valid (pop_valid),
        .rec_ready (pop_ready),
        .rec_data  (pop_data),
        .out_valid (verdict_out.valid),
        .out_ready (verdict_out.ready),
        .out_data  (out_data)
    );

    assign verdict_out.data.frame_status    = out_data.frame_status;
    assign verdict_out.data.sequence_number = out_data.sequence_number;
    assign verdict_out.data.frame_length    = out_data.frame_length;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the telemetry frame checker: byte stream in, verdicts out.
`timescale 1ns / 1ps

module tb_top;
    import tfc_pkg::*;

    localparam int MAX_BYTES         = 256;
    localparam int CYCLE_LIMIT       = 200000;
    localparam int SMALL_PHASE_BYTES = 85;
    localparam int DRAIN_CYCLES      = 8;
    localparam int REPORT_LIMIT      = 10;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;

    tfc_stream_if #(.payload_t(byte_req_t)) frame_if ();
    tfc_stream_if #(.payload_t(verdict_t))  verdict_if ();

    telemetry_frame_checker_unit #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_in    (frame_if),
        .verdict_out (verdict_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Bytes waiting to be sent, verdicts waiting to arrive
    byte_req_t byte_backlog[$];
    verdict_t  verdict_backlog[$];

    int src_idle_pct;
    int snk_idle_pct;

    // Mirror of the register file
    logic [31:0] mdl_accept;
    logic [31:0] mdl_ignore;
    logic [8:0]  mdl_len;

    // Mirror of the per-frame state
    int          frm_pos;
    logic [15:0] frm_crc;
    logic [31:0] frm_magic;
    logic [15:0] frm_seq;
    logic [15:0] frm_tail;

    int bytes_queued;
    int frames_queued;
    int verdicts_checked;
    int mismatches;
    int cycles;

    // CRC-16 CCITT, one data bit at a time, MSB first
    function automatic logic [15:0] ccitt_update(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ d[i];
            r  = {r[14:0], 1'b0};
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function void clear_frame();
        frm_pos   = 0;
        frm_crc   = CRC_INIT;
        frm_magic = '0;
        frm_seq   = '0;
        frm_tail  = '0;
    endfunction

    // Advance the frame mirror by one byte; a last byte yields one verdict
    function void absorb_byte(input byte_req_t r);
        logic [31:0]   mw;
        frame_status_t st;
        verdict_t      v;
        if (frm_pos < MAX_BYTES)
        begin
            if (frm_pos < 4)
                frm_magic = {r.received_byte, frm_magic[31:8]};
            if (frm_pos == 6)
                frm_seq[7:0] = r.received_byte;
            else if (frm_pos == 7)
                frm_seq[15:8] = r.received_byte;
            // CRC runs two bytes behind: the last two are the stored CRC
            if (frm_pos >= 2)
                frm_crc = ccitt_update(frm_crc, frm_tail[7:0]);
            frm_tail = {r.received_byte, frm_tail[15:8]};
            frm_pos++;
        end
        else
        begin
            frm_pos = MAX_BYTES + 1;
        end

        if (r.last_byte)
        begin
            mw = (frm_pos >= 4) ? frm_magic : 32'h0;
            if (frm_pos > MAX_BYTES)
                st = ST_OVERSIZE;
            else if (mw == mdl_ignore)
                st = ST_REPLY;
            else if (mw != mdl_accept)
                st = ST_OTHER;
            else if (frm_pos != mdl_len)
                st = ST_BAD_LEN;
            else if (frm_tail != frm_crc)
                st = ST_BAD_CRC;
            else
                st = ST_VALID;
            v.frame_status    = st;
            v.sequence_number = frm_seq;
            v.frame_length    = frm_pos[8:0];
            verdict_backlog.push_back(v);
            clear_frame();
        end
    endfunction

    // Queue one frame; fill < 0 means random body bytes
    task automatic push_frame(input int len, input int fill, input bit put_magic,
                              input logic [31:0] magic, input bit fix_crc, input bit spoil);
        logic [7:0]  fb[$];
        logic [15:0] c;
        byte_req_t   r;
        int          idx;
        fb = {};
        for (int i = 0; i < len; i++)
            fb.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        if (put_magic)
            for (int i = 0; i < 4 && i < len; i++)
                fb[i] = magic[8*i +: 8];
        if (fix_crc && len >= 2)
        begin
            c = CRC_INIT;
            for (int i = 0; i < len - 2; i++)
                c = ccitt_update(c, fb[i]);
            fb[len-2] = c[7:0];
            fb[len-1] = c[15:8];
        end
        // flip one bit anywhere in the frame
        if (spoil)
        begin
            idx     = $urandom_range(len - 1, 0);
            fb[idx] = fb[idx] ^ (8'h01 << $urandom_range(7, 0));
        end
        for (int i = 0; i < len; i++)
        begin
            r.received_byte = fb[i];
            r.last_byte     = (i == len - 1);
            byte_backlog.push_back(r);
        end
        bytes_queued += len;
        frames_queued++;
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [31:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_ACCEPT_MAGIC:    mdl_accept = val;
            CFG_IGNORE_MAGIC:    mdl_ignore = val;
            CFG_EXPECTED_LENGTH: mdl_len    = val[8:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] accept, input logic [31:0] ignore,
                             input logic [8:0] len);
        cfg_write(CFG_ACCEPT_MAGIC, accept);
        cfg_write(CFG_IGNORE_MAGIC, ignore);
        cfg_write(CFG_EXPECTED_LENGTH, {23'h0, len});
    endtask

    // Wait until every byte is sent and every verdict is back, then let the pipe settle
    task automatic wait_idle();
        do
            @(posedge clk);
        while (byte_backlog.size() != 0 || frame_if.valid || verdict_backlog.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Byte request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_if.valid <= 1'b0;
            frame_if.data  <= '0;
        end
        else if (!frame_if.valid || frame_if.ready)
        begin
            if (byte_backlog.size() != 0 && $urandom_range(99, 0) >= src_idle_pct)
            begin
                frame_if.valid <= 1'b1;
                frame_if.data  <= byte_backlog.pop_front();
            end
            else
            begin
                frame_if.valid <= 1'b0;
            end
        end
    end

    // Verdict ready with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            verdict_if.ready <= 1'b0;
        else
            verdict_if.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
    end

    // Predict on every accepted byte
    always @(posedge clk)
    begin
        if (rst_n && frame_if.valid && frame_if.ready)
            absorb_byte(frame_if.data);
    end

    // Compare every accepted verdict with the oldest prediction
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && verdict_if.valid && verdict_if.ready)
        begin
            if (verdict_backlog.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected verdict: status %0d seq %h len %0d",
                             verdict_if.data.frame_status, verdict_if.data.sequence_number,
                             verdict_if.data.frame_length);
            end
            else
            begin
                want = verdict_backlog.pop_front();
                if (verdict_if.data.frame_status !== want.frame_status ||
                    verdict_if.data.sequence_number !== want.sequence_number ||
                    verdict_if.data.frame_length !== want.frame_length)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("verdict %0d: status exp %0d got %0d, seq exp %h got %h, len exp %0d got %0d",
                                 verdicts_checked, want.frame_status,
                                 verdict_if.data.frame_status, want.sequence_number,
                                 verdict_if.data.sequence_number, want.frame_length,
                                 verdict_if.data.frame_length);
                end
            end
            verdicts_checked++;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycles, verdict_backlog.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int k;
        int gl;
        int wl;
        int phase_start;

        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = CFG_ACCEPT_MAGIC;
        cfg_data         = '0;
        frame_if.valid   = 1'b0;
        frame_if.data    = '0;
        verdict_if.ready = 1'b0;
        src_idle_pct     = 10;
        snk_idle_pct     = 52;
        bytes_queued     = 0;
        frames_queued    = 0;
        verdicts_checked = 0;
        mismatches       = 0;
        cycles           = 0;
        mdl_accept       = ACCEPT_MAGIC_RST;
        mdl_ignore       = IGNORE_MAGIC_RST;
        mdl_len          = EXPECTED_LENGTH_RST;
        clear_frame();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: short frames as zero magic, minimal valid frame, bad CRC, bad length
        configure(ACCEPT_MAGIC_RST, 32'h0000_0000, 9'd8);
        push_frame(1, 8'hFF, 0, 32'h0, 0, 0);
        push_frame(3, 8'h00, 0, 32'h0, 0, 0);
        push_frame(8, 8'h00, 1, ACCEPT_MAGIC_RST, 1, 0);
        push_frame(8, 8'hFF, 1, ACCEPT_MAGIC_RST, 0, 0);
        push_frame(6, -1, 1, ACCEPT_MAGIC_RST, 1, 0);
        wait_idle();

        // Random phases, each under its own register setting
        for (int p = 0; p < 6; p++)
        begin
            if (p < 2)
            begin
                src_idle_pct = 10;
                snk_idle_pct = 52;
            end
            else if (p < 4)
            begin
                src_idle_pct = 52;
                snk_idle_pct = 10;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            case (p)
                0: configure($urandom, $urandom, 9'($urandom_range(16, 8)));
                1: configure(32'h0000_0000, 32'hFFFF_FFFF, 9'd8);
                2: configure(32'hFFFF_FFFF, 32'h0000_0000, 9'd256);
                3: configure(ACCEPT_MAGIC_RST, IGNORE_MAGIC_RST, 9'($urandom_range(24, 9)));
                4: configure($urandom, $urandom, 9'($urandom_range(12, 8)));
                default: configure($urandom, $urandom, EXPECTED_LENGTH_RST);
            endcase

            // Longest valid frame and frames past the maximum
            if (p == 2)
            begin
                push_frame(MAX_BYTES, -1, 1, mdl_accept, 1, 0);
                push_frame(MAX_BYTES + 1, -1, 1, mdl_accept, 1, 0);
                push_frame(MAX_BYTES + $urandom_range(12, 2), -1, 0, 32'h0, 0, 0);
            end

            phase_start = bytes_queued;
            while (bytes_queued - phase_start < SMALL_PHASE_BYTES)
            begin
                k  = $urandom_range(99, 0);
                gl = (mdl_len > 64) ? $urandom_range(40, 8) : int'(mdl_len);
                if (k < 62)
                    push_frame(gl, -1, 1, mdl_accept, 1, 0);
                else if (k < 72)
                    push_frame(gl, -1, 1, mdl_accept, 1, 1);
                else if (k < 80)
                    push_frame($urandom_range(20, 4), -1, 1, mdl_ignore,
                               $urandom_range(1, 0), 0);
                else if (k < 88)
                begin
                    // near-miss length with a correct CRC
                    if ($urandom_range(1, 0))
                        wl = gl + int'($urandom_range(3, 1));
                    else
                        wl = gl - int'($urandom_range(3, 1));
                    if (wl < 1)
                        wl = 1;
                    if (wl > MAX_BYTES)
                        wl = MAX_BYTES - 1;
                    push_frame(wl, -1, 1, mdl_accept, 1, 0);
                end
                else if (k < 96)
                    push_frame($urandom_range(12, 1), -1, 0, 32'h0, 0, 0);
                else
                    push_frame($urandom_range(3, 1), -1, 0, 32'h0, 0, 0);
            end
            wait_idle();
        end

        $display("Sent %0d frames in %0d bytes under seven register settings,",
                 frames_queued, bytes_queued);
        $display("compared %0d verdicts with %0d mismatches.", verdicts_checked, mismatches);
        if (mismatches == 0 && verdict_backlog.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
